### hdl/mtr_pkg.sv
// ----------------------------------------------------------------------------
// mtr_pkg
// shared types and constants of the message trace ring recorder
// ----------------------------------------------------------------------------
package mtr_pkg;

    localparam int MTR_DEPTH = 64;          // default number of trace slots
    localparam int MSG_W     = 64;
    localparam int STAMP_W   = 32;
    localparam int CMD_W     = 2;
    localparam int Q_DEPTH   = 4;           // request queue, power of two
    localparam int QAW       = $clog2(Q_DEPTH);

    // command codes
    localparam logic [CMD_W-1:0] CMD_REC_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REC_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE      = 2'd3;

    // one queued request
    typedef struct packed {
        logic               dump;
        logic               dir;
        logic [STAMP_W-1:0] stamp;
        logic [MSG_W-1:0]   message;
    } t_req;

endpackage

### hdl/mtr_front.sv
// ----------------------------------------------------------------------------
// mtr_front
// command intake: decodes the command and pushes a request into the queue
// ----------------------------------------------------------------------------
module mtr_front (
    input  logic                       i_start,
    input  logic [mtr_pkg::CMD_W-1:0]  i_cmd,
    input  logic [mtr_pkg::MSG_W-1:0]  i_message,
    input  logic [mtr_pkg::STAMP_W-1:0] i_timestamp,
    input  logic                       i_full,
    output logic                       o_busy,
    output logic                       o_push,
    output mtr_pkg::t_req              o_req
);
    import mtr_pkg::*;

    logic w_accept;

    assign o_busy   = i_full;
    assign w_accept = i_start & ~i_full;

    always_comb begin
        o_push        = 1'b0;
        o_req.dump    = 1'b0;
        o_req.dir     = 1'b0;
        o_req.stamp   = i_timestamp;
        o_req.message = i_message;
        unique case (i_cmd)
            CMD_REC_READ: begin
                o_push = w_accept;
            end
            CMD_REC_WRITE: begin
                o_push    = w_accept;
                o_req.dir = 1'b1;
            end
            CMD_DUMP: begin
                o_push     = w_accept;
                o_req.dump = 1'b1;
            end
            CMD_NONE: begin
                // unused code: taken and dropped
                o_push = 1'b0;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

### hdl/mtr_queue.sv
// ----------------------------------------------------------------------------
// mtr_queue
// short request queue between intake and execution
// ----------------------------------------------------------------------------
module mtr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mtr_pkg::t_req i_req,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output mtr_pkg::t_req o_head
);
    import mtr_pkg::*;

    t_req               r_mem [Q_DEPTH];
    logic [QAW-1:0]     r_wr_ptr;
    logic [QAW-1:0]     r_rd_ptr;
    logic [QAW:0]       r_count;
    logic [QAW-1:0]     n_wr_ptr;
    logic [QAW-1:0]     n_rd_ptr;
    logic [QAW:0]       n_count;

    assign o_full  = (r_count == (QAW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // pointers wrap naturally, depth is a power of two
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(Q_DEPTH))
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
`endif

endmodule

### hdl/mtr_back.sv
// ----------------------------------------------------------------------------
// mtr_back
// request execution: trace store, ring pointers and dump walker
// ----------------------------------------------------------------------------
module mtr_back #(
    parameter int DEPTH = mtr_pkg::MTR_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_wdata,
    input  logic                        i_req_valid,
    input  mtr_pkg::t_req               i_req,
    output logic                        o_pop,
    output logic                        o_valid,
    output logic                        o_direction,
    output logic [mtr_pkg::STAMP_W-1:0] o_stamp,
    output logic [mtr_pkg::MSG_W-1:0]   o_contents,
    output logic                        o_last
);
    import mtr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = AW + 1;
    localparam int EW = 1 + STAMP_W + MSG_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] v);
        return (v == AW'(DEPTH - 1)) ? '0 : AW'(v + 1'b1);
    endfunction

    logic [EW-1:0] r_store [DEPTH];
    logic [EW-1:0] r_rd_q;

    logic          r_circular;
    logic          r_state;
    logic [AW-1:0] r_oldest;
    logic [NW-1:0] r_next;
    logic [AW-1:0] r_rd_idx;
    logic [NW-1:0] r_remain;
    logic          r_out_valid;
    logic          r_out_last;

    logic          n_state;
    logic [AW-1:0] n_oldest;
    logic [NW-1:0] n_next;
    logic [AW-1:0] n_rd_idx;
    logic [NW-1:0] n_remain;
    logic          n_out_valid;
    logic          n_out_last;

    logic          w_wr_en;
    logic [AW-1:0] w_wr_slot;
    logic          w_rd_en;
    logic          w_next_end;
    logic [NW-1:0] w_held;
    logic [AW-1:0] w_old0;
    logic [AW-1:0] w_slot;
    logic [AW-1:0] w_inc;
    logic          w_refuse;

    assign w_next_end = (r_next == NW'(DEPTH));

    // held entries, next - oldest modulo the ring
    assign w_held = (r_next >= {1'b0, r_oldest})
                  ? NW'(r_next - {1'b0, r_oldest})
                  : NW'(r_next + NW'(DEPTH) - {1'b0, r_oldest});

    // circular record: a pointer left at the end by stop mode restarts at 0
    assign w_old0 = (w_next_end && r_oldest == '0) ? wrap_inc('0) : r_oldest;
    assign w_slot = w_next_end ? '0 : r_next[AW-1:0];
    assign w_inc  = wrap_inc(w_slot);

    // stop mode: full at the end, or wrapped and one short of oldest
    assign w_refuse = w_next_end
                   || (({1'b0, r_oldest} > r_next)
                       && (NW'(r_next + 1'b1) == {1'b0, r_oldest}));

    always_comb begin
        n_state     = r_state;
        n_oldest    = r_oldest;
        n_next      = r_next;
        n_rd_idx    = r_rd_idx;
        n_remain    = r_remain;
        n_out_valid = 1'b0;
        n_out_last  = 1'b0;
        o_pop       = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_slot   = w_slot;
        w_rd_en     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_pop = 1'b1;
                    if (i_req.dump) begin
                        if (w_held != '0) begin
                            n_state  = ST_DUMP;
                            n_rd_idx = r_oldest;
                            n_remain = w_held;
                        end
                    end else if (r_circular) begin
                        w_wr_en   = 1'b1;
                        w_wr_slot = w_slot;
                        n_next    = {1'b0, w_inc};
                        n_oldest  = (w_inc == w_old0) ? wrap_inc(w_old0) : w_old0;
                    end else if (!w_refuse) begin
                        w_wr_en   = 1'b1;
                        w_wr_slot = r_next[AW-1:0];
                        n_next    = NW'(r_next + 1'b1);
                    end
                end
            end
            ST_DUMP: begin
                w_rd_en     = 1'b1;
                n_out_valid = 1'b1;
                n_out_last  = (r_remain == NW'(1));
                n_rd_idx    = wrap_inc(r_rd_idx);
                n_remain    = NW'(r_remain - 1'b1);
                if (r_remain == NW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_circular  <= 1'b1;
            r_state     <= ST_IDLE;
            r_oldest    <= '0;
            r_next      <= '0;
            r_rd_idx    <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_circular <= i_cfg_wdata;
            end
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_next      <= n_next;
            r_rd_idx    <= n_rd_idx;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
        end
    end

    // trace store, one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[w_wr_slot] <= {i_req.dir, i_req.stamp, i_req.message};
        end
        if (w_rd_en) begin
            r_rd_q <= r_store[r_rd_idx];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_last      = r_out_last;
    assign o_direction = r_rd_q[EW-1];
    assign o_stamp     = r_rd_q[EW-2 -: STAMP_W];
    assign o_contents  = r_rd_q[MSG_W-1:0];

`ifndef SYNTH
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next <= NW'(DEPTH)) && ({1'b0, r_oldest} < NW'(DEPTH)))
        else $error("ring pointer out of range");
    a_dump_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |-> (r_remain != '0))
        else $error("dump walking with nothing left");
    a_out_from_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state == ST_DUMP))
        else $error("result without a dump step");
    a_last_ends_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_state == ST_IDLE))
        else $error("dump still running after last record");
`endif

endmodule

### hdl/message_trace_ring_recorder.sv
// ----------------------------------------------------------------------------
// message_trace_ring_recorder
// trace recorder for 64-bit messages with circular and stop modes and dump
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with i_start high and o_busy low; o_busy
// rises only when the four-deep request queue is full, so record requests
// are taken one per cycle for as long as the queue drains. In the execution
// side a record request is a single write to the trace store. A dump of n
// held entries occupies the execution side while it takes the request and
// then makes one store read per entry, so the records come out
// on consecutive cycles, oldest first, after the dump state and the
// registered store read. The single-port trace store sets this pace. Each
// record is on the o_ ports for exactly one cycle with o_valid high and
// must be taken then; o_last marks the newest. An empty store gives no
// record. Requests arriving during a dump wait in the queue.
// ----------------------------------------------------------------------------
module message_trace_ring_recorder #(
    parameter int DEPTH = mtr_pkg::MTR_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // mode register: 1 overwrite oldest, 0 stop when full
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_wdata,
    // request side
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [mtr_pkg::CMD_W-1:0]   i_cmd,
    input  logic [mtr_pkg::MSG_W-1:0]   i_message,
    input  logic [mtr_pkg::STAMP_W-1:0] i_timestamp,
    // result side, no back pressure
    output logic                        o_valid,
    output logic                        o_direction,
    output logic [mtr_pkg::STAMP_W-1:0] o_stamp,
    output logic [mtr_pkg::MSG_W-1:0]   o_contents,
    output logic                        o_last
);
    import mtr_pkg::*;

    // front to queue
    logic w_push;
    t_req w_push_req;
    logic w_full;

    // queue to back
    logic w_head_valid;
    t_req w_head;
    logic w_pop;

    // intake: decode and drop the unused command code
    mtr_front u_front (
        .i_start     (i_start),
        .i_cmd       (i_cmd),
        .i_message   (i_message),
        .i_timestamp (i_timestamp),
        .i_full      (w_full),
        .o_busy      (o_busy),
        .o_push      (w_push),
        .o_req       (w_push_req)
    );

    // decouples intake from execution during dumps
    mtr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_push_req),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_head  (w_head)
    );

    // trace store, ring pointers, mode register and dump walker
    mtr_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (w_head_valid),
        .i_req       (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_direction (o_direction),
        .o_stamp     (o_stamp),
        .o_contents  (o_contents),
        .o_last      (o_last)
    );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the message trace ring recorder
// ----------------------------------------------------------------------------
// A short table of directed requests covers the empty store, the unused
// command, extreme messages and stamps, and both modes. A random part
// follows in phases, each under a new mode setting, mostly record requests
// with some dumps mixed in. Over the phases the store fills, wraps in
// circular mode, refuses records in stop mode, and meets the circular
// restart after a full stop-mode store. Every dump record is checked field
// by field against a behavioral copy of the trace store or a typed-in value.
// ----------------------------------------------------------------------------
module testbench;
    import mtr_pkg::*;

    localparam int DEPTH        = MTR_DEPTH;
    localparam int RAND_ITEMS   = 393;
    // quiet cycles once nothing is awaited: request queue plus a spare dump
    localparam int DRAIN_CYCLES = 24;
    localparam int LIMIT_CYCLES = 200_000;

    // one dump record as it appears on the result ports
    typedef struct packed {
        logic               dir;
        logic [STAMP_W-1:0] stamp;
        logic [MSG_W-1:0]   contents;
        logic               last;
    } t_rec;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    // directed row: a request or a mode write; chk marks a row whose dump
    // outcome is typed in (chk_n = 0 no record, 1 one record with last set)
    typedef struct packed {
        t_row_kind          kind;
        logic [CMD_W-1:0]   cmd;
        logic [MSG_W-1:0]   msg;
        logic [STAMP_W-1:0] ts;
        logic               mode;
        logic               chk;
        logic               chk_n;
        logic               e_dir;
        logic [STAMP_W-1:0] e_stamp;
        logic [MSG_W-1:0]   e_contents;
    } t_row;

    localparam int N_ROWS = 19;
    localparam t_row DIRECTED [N_ROWS] = '{
        // empty store right after reset gives nothing
        '{ROW_REQ, CMD_DUMP, '0, '0, 1'b0, 1'b1, 1'b0, 1'b0, '0, '0},
        // unused command must not record
        '{ROW_REQ, CMD_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
          1'b0, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_REQ, CMD_DUMP, '0, '0, 1'b0, 1'b1, 1'b0, 1'b0, '0, '0},
        // one written entry at the top of every field
        '{ROW_REQ, CMD_REC_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
          1'b0, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_REQ, CMD_DUMP, '0, '0, 1'b0, 1'b1, 1'b1, 1'b1,
          32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
        '{ROW_REQ, CMD_REC_READ, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_REQ, CMD_DUMP, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_REQ, CMD_REC_READ, 64'h8000_0000_0000_0000, 32'h8000_0000,
          1'b0, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_REQ, CMD_REC_WRITE, 64'h0000_0000_0000_0001, 32'h0000_0001,
          1'b0, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_REQ, CMD_REC_READ, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA,
          1'b0, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_REQ, CMD_DUMP, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0},
        // stop mode
        '{ROW_CFG, CMD_NONE, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_REQ, CMD_REC_WRITE, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555,
          1'b0, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_REQ, CMD_NONE, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0},
        // two dumps back to back
        '{ROW_REQ, CMD_DUMP, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_REQ, CMD_DUMP, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0},
        // back to circular mode
        '{ROW_CFG, CMD_NONE, '0, '0, 1'b1, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_REQ, CMD_REC_READ, 64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF,
          1'b0, 1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_REQ, CMD_DUMP, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic                 i_cfg_wdata;
    logic                 i_start;
    logic                 o_busy;
    logic [CMD_W-1:0]     i_cmd;
    logic [MSG_W-1:0]     i_message;
    logic [STAMP_W-1:0]   i_timestamp;
    logic                 o_valid;
    logic                 o_direction;
    logic [STAMP_W-1:0]   o_stamp;
    logic [MSG_W-1:0]     o_contents;
    logic                 o_last;

    message_trace_ring_recorder #(
        .DEPTH (DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_cmd       (i_cmd),
        .i_message   (i_message),
        .i_timestamp (i_timestamp),
        .o_valid     (o_valid),
        .o_direction (o_direction),
        .o_stamp     (o_stamp),
        .o_contents  (o_contents),
        .o_last      (o_last)
    );

    // behavioral trace store
    logic [MSG_W-1:0]   trace_msg   [DEPTH];
    logic [STAMP_W-1:0] trace_stamp [DEPTH];
    logic               trace_dir   [DEPTH];
    int                 head_slot;      // oldest held entry
    int                 tail_slot;      // slot for the next record, 0..DEPTH
    logic               ring_mode;      // 1 overwrite oldest, 0 stop when full

    t_rec   dump_out [DEPTH];           // records of the latest dump request
    t_rec   awaited_records [$];        // dump records not yet seen on the ports
    int     errors = 0;
    int     cycles = 0;
    bit     burst;                      // back-to-back stretch of requests

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit, far above the slowest correct run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // applies one accepted request to the behavioral store, n = records out
    task automatic trace_update(input logic [CMD_W-1:0] cmd,
                                input logic [MSG_W-1:0] msg,
                                input logic [STAMP_W-1:0] ts, output int n);
        int held;
        int slot;
        n = 0;
        case (cmd)
            CMD_REC_READ, CMD_REC_WRITE: begin
                if (ring_mode) begin
                    // a store left full by stop mode restarts at slot 0
                    if (tail_slot >= DEPTH) begin
                        tail_slot = 0;
                        if (head_slot == 0)
                            head_slot = 1;
                    end
                    trace_msg[tail_slot]   = msg;
                    trace_stamp[tail_slot] = ts;
                    trace_dir[tail_slot]   = (cmd == CMD_REC_WRITE);
                    tail_slot = (tail_slot + 1) % DEPTH;
                    // ring full: drop the oldest entry
                    if (tail_slot == head_slot)
                        head_slot = (head_slot + 1) % DEPTH;
                end else if (tail_slot < DEPTH &&
                             !(tail_slot < head_slot && tail_slot + 1 == head_slot)) begin
                    trace_msg[tail_slot]   = msg;
                    trace_stamp[tail_slot] = ts;
                    trace_dir[tail_slot]   = (cmd == CMD_REC_WRITE);
                    tail_slot = tail_slot + 1;
                end
                // otherwise stop mode refuses the record
            end
            CMD_DUMP: begin
                held = (tail_slot >= head_slot) ? tail_slot - head_slot
                                                : tail_slot + DEPTH - head_slot;
                slot = head_slot;
                for (int k = 0; k < held; k++) begin
                    dump_out[k] = '{trace_dir[slot], trace_stamp[slot], trace_msg[slot],
                                    (k == held - 1)};
                    slot = (slot + 1) % DEPTH;
                end
                n = held;
            end
            default: ;  // unused command leaves everything as is
        endcase
    endtask

    // sender gap before each request, with stretches of back-to-back requests
    function automatic int draw_gap();
        if ($urandom_range(0, 15) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 18);
    endfunction

    // drives one request after the idle gap given by gap and waits for it to be taken;
    // start stays high when the next request follows without a gap
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [MSG_W-1:0] msg,
                                input logic [STAMP_W-1:0] ts,
                                input int gap, input bit use_model);
        int n;
        @(negedge i_clk);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start     <= 1'b1;
        i_cmd       <= cmd;
        i_message   <= msg;
        i_timestamp <= ts;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        // taken at this edge
        trace_update(cmd, msg, ts, n);
        if (use_model)
            for (int k = 0; k < n; k++)
                awaited_records.push_back(dump_out[k]);
    endtask

    // holds requests off until every awaited record is out and the request
    // queue has had time to drain its records
    task automatic wait_idle();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (awaited_records.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic mode);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        ring_mode = mode;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic report(input string what, input logic [MSG_W-1:0] want,
                          input logic [MSG_W-1:0] got);
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    endtask

    // result checker: every strobed record must match the oldest awaited one
    always @(posedge i_clk) begin
        t_rec want;
        if (i_rst_n && o_valid) begin
            if (awaited_records.size() == 0) begin
                errors++;
                $display("%0t: unexpected record expected none got dir %0b stamp %0h %0h last %0b",
                         $time, o_direction, o_stamp, o_contents, o_last);
            end else begin
                want = awaited_records.pop_front();
                if (o_direction !== want.dir)
                    report("direction", MSG_W'(want.dir), MSG_W'(o_direction));
                if (o_stamp !== want.stamp)
                    report("stamp", MSG_W'(want.stamp), MSG_W'(o_stamp));
                if (o_contents !== want.contents)
                    report("contents", want.contents, o_contents);
                if (o_last !== want.last)
                    report("last", MSG_W'(want.last), MSG_W'(o_last));
            end
        end
    end

    initial begin
        t_row             row;
        logic [CMD_W-1:0] cmd;
        int               r;
        int               total;
        int               phase;
        int               n_items;

        burst       = 1'b0;
        head_slot   = 0;
        tail_slot   = 0;
        ring_mode   = 1'b1;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        i_start     = 1'b0;
        i_cmd       = CMD_NONE;
        i_message   = '0;
        i_timestamp = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (DIRECTED[i]) begin
            row = DIRECTED[i];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                set_mode(row.mode);
            end else begin
                send_request(row.cmd, row.msg, row.ts, draw_gap(), !row.chk);
                if (row.chk && row.chk_n)
                    awaited_records.push_back('{row.e_dir, row.e_stamp, row.e_contents, 1'b1});
            end
        end

        // random phases: the first ones alternate stop and circular so the
        // store fills, gets refused, restarts in circular mode and wraps
        total = 0;
        phase = 0;
        while (total < RAND_ITEMS) begin
            wait_idle();
            set_mode(phase < 4 ? logic'(phase % 2) : logic'($urandom_range(0, 1)));
            n_items = (phase < 4) ? $urandom_range(70, 100) : $urandom_range(30, 80);
            for (int k = 0; k < n_items && total < RAND_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    cmd = CMD_NONE;
                else if (r < 11)
                    cmd = CMD_DUMP;
                else
                    cmd = $urandom_range(0, 1) ? CMD_REC_WRITE : CMD_REC_READ;
                send_request(cmd, {$urandom, $urandom}, $urandom, draw_gap(), 1'b1);
                total++;
            end
            phase++;
        end

        wait_idle();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
